[sv/mlk_pkg.sv]
package mlk_pkg;

	localparam int unsigned CharWidth = 8;
	localparam int unsigned TimeWidth = 16;
	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned PatWidth = 4;
	localparam int unsigned CountWidth = 3;
	localparam int unsigned LetterCount = 26;

	localparam logic [TimeWidth-1:0] DOT_TIME_RESET = 16'd75;
	localparam logic [TimeWidth-1:0] DASH_TIME_RESET = 16'd375;
	localparam logic [TimeWidth-1:0] ELEMENT_GAP_RESET = 16'd125;
	localparam logic [TimeWidth-1:0] LETTER_GAP_RESET = 16'd250;

	localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CharWidth-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CharWidth-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CharWidth-1:0] CHAR_LOWER_Z = 8'h7A;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_DOT_TIME = 2'd0,
		REG_DASH_TIME = 2'd1,
		REG_ELEMENT_GAP = 2'd2,
		REG_LETTER_GAP = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DUR_DOT = 2'd0,
		DUR_DASH = 2'd1,
		DUR_EGAP = 2'd2,
		DUR_LGAP = 2'd3
	} dur_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ON = 2'd1,
		ST_OFF = 2'd2,
		ST_GAP = 2'd3
	} state_t;

	typedef struct packed {
		logic key_on;
		dur_sel_t sel;
		logic last;
	} seg_t;

	// high nibble: element count; bit i of low nibble: element i is a dash
	localparam logic [7:0] LETTER_CODE [LetterCount] = '{
		8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
		8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
		8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
	};

endpackage

[sv/morse_letter_keyer_unit.sv]
// A letter's first beat passes the state register, then the output register.
// Throughput: one segment beat per cycle unless m_axis_tready stalls. A letter of n
// elements gives n on/off pairs paced by the element shift register, then a gap beat.
// A non-letter gives no beat. The next character is taken in the cycle the letter-gap
// beat is issued. Reset (arst_n low, asynchronous): sequencer idle, output empty,
// times at 75, 375, 125 and 250 ms.
module morse_letter_keyer_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] char_code
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // [15:0] duration_ms
	output logic m_axis_tuser, // [0] key_on
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [mlk_pkg::CfgIndexWidth-1:0] cfg_index,
	input logic [mlk_pkg::TimeWidth-1:0] cfg_data
);

	logic [mlk_pkg::TimeWidth-1:0] dot_time_q, dash_time_q, element_gap_q, letter_gap_q;
	logic [mlk_pkg::TimeWidth-1:0] dur;
	logic [mlk_pkg::TimeWidth-1:0] out_data_q;
	logic out_valid_q, out_user_q, out_last_q;
	logic advance, seg_valid;
	mlk_pkg::seg_t seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_time_q <= mlk_pkg::DOT_TIME_RESET;
			dash_time_q <= mlk_pkg::DASH_TIME_RESET;
			element_gap_q <= mlk_pkg::ELEMENT_GAP_RESET;
			letter_gap_q <= mlk_pkg::LETTER_GAP_RESET;
		end else if (cfg_we) begin
			case (mlk_pkg::cfg_reg_t'(cfg_index))
				mlk_pkg::REG_DOT_TIME: dot_time_q <= cfg_data;
				mlk_pkg::REG_DASH_TIME: dash_time_q <= cfg_data;
				mlk_pkg::REG_ELEMENT_GAP: element_gap_q <= cfg_data;
				mlk_pkg::REG_LETTER_GAP: letter_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = !out_valid_q || m_axis_tready;

	mlk_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_char(s_axis_tdata),
		.in_ready(s_axis_tready),
		.advance(advance),
		.seg_valid(seg_valid),
		.seg(seg)
	);

	always_comb begin
		case (seg.sel)
			mlk_pkg::DUR_DOT: dur = dot_time_q;
			mlk_pkg::DUR_DASH: dur = dash_time_q;
			mlk_pkg::DUR_EGAP: dur = element_gap_q;
			mlk_pkg::DUR_LGAP: dur = letter_gap_q;
			default: dur = element_gap_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && seg_valid) begin
			out_data_q <= dur;
			out_user_q <= seg.key_on;
			out_last_q <= seg.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;
	assign m_axis_tlast = out_last_q;

endmodule

[sv/mlk_seq.sv]
module mlk_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [mlk_pkg::CharWidth-1:0] in_char,
	output logic in_ready,
	input logic advance,
	output logic seg_valid,
	output mlk_pkg::seg_t seg
);

	mlk_pkg::state_t state_q, state_d;
	logic [mlk_pkg::CountWidth-1:0] cnt_q;
	logic [mlk_pkg::PatWidth-1:0] pat_q;
	logic load, shift, is_letter;
	logic [4:0] idx;
	logic [7:0] code;

	assign is_letter = ((in_char >= mlk_pkg::CHAR_UPPER_A) && (in_char <= mlk_pkg::CHAR_UPPER_Z))
		|| ((in_char >= mlk_pkg::CHAR_LOWER_A) && (in_char <= mlk_pkg::CHAR_LOWER_Z));
	assign idx = in_char[4:0] - 5'd1;
	assign code = (idx < 5'(mlk_pkg::LetterCount)) ? mlk_pkg::LETTER_CODE[idx] : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pat_q <= '0;
		end else if (load) begin
			cnt_q <= code[6:4];
			pat_q <= code[3:0];
		end else if (shift) begin
			cnt_q <= cnt_q - 3'd1;
			pat_q <= {1'b0, pat_q[mlk_pkg::PatWidth-1:1]};
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		seg_valid = 1'b0;
		seg = '{key_on: 1'b0, sel: mlk_pkg::DUR_EGAP, last: 1'b0};
		load = 1'b0;
		shift = 1'b0;
		case (state_q)
			mlk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mlk_pkg::ST_ON: begin
				seg_valid = 1'b1;
				seg.key_on = 1'b1;
				seg.sel = pat_q[0] ? mlk_pkg::DUR_DASH : mlk_pkg::DUR_DOT;
				if (advance) begin
					state_d = mlk_pkg::ST_OFF;
				end
			end
			mlk_pkg::ST_OFF: begin
				seg_valid = 1'b1;
				if (advance) begin
					shift = 1'b1;
					state_d = (cnt_q == 3'd1) ? mlk_pkg::ST_GAP : mlk_pkg::ST_ON;
				end
			end
			mlk_pkg::ST_GAP: begin
				seg_valid = 1'b1;
				seg.sel = mlk_pkg::DUR_LGAP;
				seg.last = 1'b1;
				if (advance) begin
					in_ready = 1'b1;
					state_d = mlk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlk_pkg::ST_IDLE;
			end
		endcase
		// take next character; drop anything that is not a letter
		if (in_ready && in_valid && is_letter) begin
			load = 1'b1;
			state_d = mlk_pkg::ST_ON;
		end
	end

endmodule

[sv/mlk_checker.sv]
module mlk_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tuser,
	input logic m_axis_tlast
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("letter gap beat keyed on");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser
		|=> m_axis_tvalid && !m_axis_tuser && !m_axis_tlast)
		else $error("key-on beat not followed by element gap");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tlast || m_axis_tready)
		else $error("character taken mid letter");

endmodule

bind morse_letter_keyer_unit mlk_checker u_mlk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
